/* src/headers_frame_segmenter_unit_assert.svh */
// Assertion macros shared by the frame segmenter RTL.
`ifndef HEADERS_FRAME_SEGMENTER_UNIT_ASSERT_SVH
`define HEADERS_FRAME_SEGMENTER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HFS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame segmenter assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame segmenter assertion failed");

`endif

/* src/hfs_pkg.sv */
// Types and constants of the header block frame segmenter.
`timescale 1ns / 1ps

package hfs_pkg;

    localparam int unsigned LEN_W       = 24;
    localparam int unsigned CNT_W       = 3;
    localparam int unsigned PLAN_DEPTH  = 6;
    localparam int unsigned QUEUE_DEPTH = 7;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [LEN_W-1:0] LEN_MAX = 24'hFFFFFF;
    localparam logic [2:0] PRIORITY_BYTES = 3'd5;

    localparam logic [1:0] OP_BEGIN  = 2'd0;
    localparam logic [1:0] OP_BYTE   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_PAD_RUN = 2'd1;
    localparam logic [1:0] KIND_HEADER  = 2'd2;
    localparam logic [1:0] KIND_STATUS  = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_OP  = 2'd1;
    localparam logic [1:0] STATUS_BAD_CFG = 2'd2;

    localparam logic [3:0] TYPE_HEADERS      = 4'd1;
    localparam logic [3:0] TYPE_CONTINUATION = 4'd9;

    localparam logic [7:0] FLAG_END_STREAM  = 8'h01;
    localparam logic [7:0] FLAG_END_HEADERS = 8'h04;
    localparam logic [7:0] FLAG_PADDED      = 8'h08;
    localparam logic [7:0] FLAG_PRIORITY    = 8'h20;

    localparam logic [CFG_IDX_W-1:0] CFG_STREAM_NUMBER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CAP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_COUNT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIO_ENABLE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIO_DEP      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIO_WEIGHT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_END_STREAM    = 3'd7;

    typedef struct packed {
        logic [30:0]      stream_number;
        logic [LEN_W-1:0] max_frame_payload;
        logic [LEN_W-1:0] first_buffer_cap;
        logic [7:0]       pad_count;
        logic             priority_enable;
        logic [31:0]      priority_dependency;
        logic [7:0]       priority_weight;
        logic             end_stream_flag;
    } cfg_t;

    typedef struct packed {
        logic             block_open;
        logic             block_done;
        logic             in_first_frame;
        logic [LEN_W-1:0] bytes_in_frame;
    } state_t;

    typedef struct packed {
        logic [1:0]       item_kind;
        logic [7:0]       out_byte;
        logic [7:0]       pad_run;
        logic [LEN_W-1:0] frame_length;
        logic [3:0]       frame_type;
        logic [7:0]       frame_flags;
        logic [1:0]       status;
        logic             last_of_run;
    } result_t;

endpackage

/* src/hfs_cmd_if.sv */
// Input channel carrying block operations.
`timescale 1ns / 1ps

interface hfs_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] block_byte;

    modport source (output valid, output opcode, output block_byte, input ready);
    modport sink (input valid, input opcode, input block_byte, output ready);
endinterface

/* src/hfs_res_if.sv */
// Output channel carrying framing results.
`timescale 1ns / 1ps

interface hfs_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  item_kind;
    logic [7:0]  out_byte;
    logic [7:0]  pad_run;
    logic [23:0] frame_length;
    logic [3:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [1:0]  status;
    logic        last_of_run;

    modport source (output valid, output item_kind, output out_byte, output pad_run,
                    output frame_length, output frame_type, output frame_flags,
                    output status, output last_of_run, input ready);
    modport sink (input valid, input item_kind, input out_byte, input pad_run,
                  input frame_length, input frame_type, input frame_flags,
                  input status, input last_of_run, output ready);
endinterface

/* src/hfs_cfg_if.sv */
// Configuration write channel.
`timescale 1ns / 1ps

interface hfs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* src/headers_frame_segmenter_unit.sv */
// Top level of the header block frame segmenter.
// The cmd channel carries one operation per transaction: begin, one encoded
// header block byte, or finish. The res channel returns the results of each
// operation in order: payload bytes, zero pad runs, frame header descriptors
// and status-only results, with last_of_run set on the final result of each.
// The cfg channel writes the eight framing registers and is always ready;
// the user must write it only while no results are pending; the block does not enforce this.
// An accepted command's results are registered into the result queue, behind
// any result still held there, and leave it through res in order. A command
// yields one to six results, each taking its own transfer on res; a command is
// accepted whenever at most one result is still queued, so while res is ready a
// stream of block bytes runs at one per cycle apart from frame boundaries. The
// result queue and its single output port set that rate.
// When res is stalled, results wait in the queue and cmd stops accepting once
// more than one result is held. Reset loads the register defaults, closes any
// block and empties the queue.
`timescale 1ns / 1ps
`include "headers_frame_segmenter_unit_assert.svh"

module headers_frame_segmenter_unit (
    input  logic        clk,
    input  logic        rst_n,
    hfs_cmd_if.sink     cmd,
    hfs_res_if.source   res,
    hfs_cfg_if.sink     cfg
);

    hfs_pkg::cfg_t                    cfg_reg;
    hfs_pkg::state_t                  state_reg;
    hfs_pkg::state_t                  state_next;
    hfs_pkg::result_t                 plan [hfs_pkg::PLAN_DEPTH];
    logic [hfs_pkg::CNT_W-1:0]        plan_count;
    hfs_pkg::result_t                 q_reg [hfs_pkg::QUEUE_DEPTH];
    hfs_pkg::result_t                 q_next [hfs_pkg::QUEUE_DEPTH];
    logic [hfs_pkg::CNT_W-1:0]        cnt_reg;
    logic [hfs_pkg::CNT_W-1:0]        cnt_next;
    logic                             cmd_take;
    logic                             res_take;
    logic                             keep_head;

    hfs_plan u_plan (
        .opcode     (cmd.opcode),
        .block_byte (cmd.block_byte),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .plan       (plan),
        .plan_count (plan_count),
        .state_next (state_next)
    );

    assign cmd.ready = (cnt_reg <= hfs_pkg::CNT_W'(1));
    assign cfg.ready = 1'b1;
    assign cmd_take  = cmd.valid && cmd.ready;
    assign res_take  = res.valid && res.ready;
    assign keep_head = (cnt_reg == hfs_pkg::CNT_W'(1)) && !res_take;

    assign res.valid        = (cnt_reg != '0);
    assign res.item_kind    = q_reg[0].item_kind;
    assign res.out_byte     = q_reg[0].out_byte;
    assign res.pad_run      = q_reg[0].pad_run;
    assign res.frame_length = q_reg[0].frame_length;
    assign res.frame_type   = q_reg[0].frame_type;
    assign res.frame_flags  = q_reg[0].frame_flags;
    assign res.status       = q_reg[0].status;
    assign res.last_of_run  = q_reg[0].last_of_run;

    always_comb
    begin
        for (int i = 0; i < hfs_pkg::QUEUE_DEPTH; i++)
        begin
            q_next[i] = q_reg[i];
        end
        cnt_next = cnt_reg - hfs_pkg::CNT_W'(res_take);
        if (cmd_take)
        begin
            cnt_next = cnt_next + plan_count;
            if (keep_head)
            begin
                for (int i = 0; i < hfs_pkg::PLAN_DEPTH; i++)
                begin
                    q_next[i + 1] = plan[i];
                end
            end
            else
            begin
                for (int i = 0; i < hfs_pkg::PLAN_DEPTH; i++)
                begin
                    q_next[i] = plan[i];
                end
            end
        end
        else if (res_take)
        begin
            for (int i = 0; i < hfs_pkg::QUEUE_DEPTH - 1; i++)
            begin
                q_next[i] = q_reg[i + 1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < hfs_pkg::QUEUE_DEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            state_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (cmd_take)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{stream_number: 31'd1, max_frame_payload: 24'd16384, default: '0};
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                hfs_pkg::CFG_STREAM_NUMBER: cfg_reg.stream_number     <= cfg.data[30:0];
                hfs_pkg::CFG_MAX_PAYLOAD:   cfg_reg.max_frame_payload <= cfg.data[23:0];
                hfs_pkg::CFG_FIRST_CAP:     cfg_reg.first_buffer_cap  <= cfg.data[23:0];
                hfs_pkg::CFG_PAD_COUNT:     cfg_reg.pad_count         <= cfg.data[7:0];
                hfs_pkg::CFG_PRIO_ENABLE:   cfg_reg.priority_enable   <= cfg.data[0];
                hfs_pkg::CFG_PRIO_DEP:      cfg_reg.priority_dependency <= cfg.data;
                hfs_pkg::CFG_PRIO_WEIGHT:   cfg_reg.priority_weight   <= cfg.data[7:0];
                hfs_pkg::CFG_END_STREAM:    cfg_reg.end_stream_flag   <= cfg.data[0];
                default:
                begin
                end
            endcase
        end
    end

    `HFS_ASSERT_SAME(a_open_done_excl, clk, rst_n, state_reg.block_done, !state_reg.block_open)
    `HFS_ASSERT_SAME(a_first_in_open, clk, rst_n, state_reg.in_first_frame, state_reg.block_open)
    `HFS_ASSERT_SAME(a_single_is_last, clk, rst_n, cnt_reg == hfs_pkg::CNT_W'(1), q_reg[0].last_of_run)
    `HFS_ASSERT_NEXT(a_finish_done, clk, rst_n, cmd_take && cmd.opcode == hfs_pkg::OP_FINISH && state_reg.block_open, state_reg.block_done && res.valid)

endmodule

/* src/hfs_plan.sv */
// Computes the result list and the next framing state for one transaction.
`timescale 1ns / 1ps

module hfs_plan (
    input  logic [1:0]                              opcode,
    input  logic [7:0]                              block_byte,
    input  hfs_pkg::cfg_t                           cfg,
    input  hfs_pkg::state_t                         state,
    output hfs_pkg::result_t                        plan [hfs_pkg::PLAN_DEPTH],
    output logic [hfs_pkg::CNT_W-1:0]               plan_count,
    output hfs_pkg::state_t                         state_next
);

    logic [7:0]                   pend_pad;
    logic [hfs_pkg::LEN_W:0]      used;
    logic                         room_zero;
    logic [hfs_pkg::LEN_W-1:0]    seal_len;
    logic [7:0]                   first_flags;
    logic                         pad_nz;
    logic [8:0]                   reserved;
    logic [hfs_pkg::LEN_W-1:0]    cap;
    logic                         cfg_bad;
    logic [hfs_pkg::CNT_W-1:0]    prefix_n;
    logic [7:0]                   seq [hfs_pkg::PLAN_DEPTH];
    hfs_pkg::result_t             pad_entry;
    hfs_pkg::result_t             hdr_entry;
    hfs_pkg::result_t             byte_entry;
    hfs_pkg::result_t             status_entry;

    always_comb
    begin
        pad_nz   = (cfg.pad_count != 8'd0);
        pend_pad = state.in_first_frame ? cfg.pad_count : 8'd0;
        used     = {1'b0, state.bytes_in_frame} + (hfs_pkg::LEN_W + 1)'(pend_pad);
        room_zero = !({1'b0, cfg.max_frame_payload} > used);
        seal_len = used[hfs_pkg::LEN_W] ? hfs_pkg::LEN_MAX : used[hfs_pkg::LEN_W-1:0];

        first_flags = 8'd0;
        if (state.in_first_frame)
        begin
            if (cfg.end_stream_flag)
            begin
                first_flags = first_flags | hfs_pkg::FLAG_END_STREAM;
            end
            if (pad_nz)
            begin
                first_flags = first_flags | hfs_pkg::FLAG_PADDED;
            end
            if (cfg.priority_enable)
            begin
                first_flags = first_flags | hfs_pkg::FLAG_PRIORITY;
            end
        end

        pad_entry           = '0;
        pad_entry.item_kind = hfs_pkg::KIND_PAD_RUN;
        pad_entry.pad_run   = pend_pad;

        hdr_entry              = '0;
        hdr_entry.item_kind    = hfs_pkg::KIND_HEADER;
        hdr_entry.frame_length = seal_len;
        hdr_entry.frame_type   = state.in_first_frame ? hfs_pkg::TYPE_HEADERS
                                                      : hfs_pkg::TYPE_CONTINUATION;
        hdr_entry.frame_flags  = first_flags;

        byte_entry           = '0;
        byte_entry.item_kind = hfs_pkg::KIND_PAYLOAD;
        byte_entry.out_byte  = block_byte;

        status_entry           = '0;
        status_entry.item_kind = hfs_pkg::KIND_STATUS;
        status_entry.status    = hfs_pkg::STATUS_BAD_OP;

        reserved = 9'(pad_nz) + (cfg.priority_enable ? 9'(hfs_pkg::PRIORITY_BYTES) : 9'd0)
                 + 9'(cfg.pad_count);
        cap = cfg.max_frame_payload;
        if (cfg.first_buffer_cap != '0 && cfg.first_buffer_cap < cap)
        begin
            cap = cfg.first_buffer_cap;
        end
        cfg_bad = (cfg.stream_number == '0) || (cfg.max_frame_payload == '0)
               || (hfs_pkg::LEN_W'(reserved) > cfg.max_frame_payload)
               || (hfs_pkg::LEN_W'(reserved) > cap);
        prefix_n = hfs_pkg::CNT_W'(pad_nz)
                 + (cfg.priority_enable ? hfs_pkg::PRIORITY_BYTES : 3'd0);

        if (pad_nz)
        begin
            seq[0] = cfg.pad_count;
            seq[1] = cfg.priority_dependency[31:24];
            seq[2] = cfg.priority_dependency[23:16];
            seq[3] = cfg.priority_dependency[15:8];
            seq[4] = cfg.priority_dependency[7:0];
            seq[5] = cfg.priority_weight;
        end
        else
        begin
            seq[0] = cfg.priority_dependency[31:24];
            seq[1] = cfg.priority_dependency[23:16];
            seq[2] = cfg.priority_dependency[15:8];
            seq[3] = cfg.priority_dependency[7:0];
            seq[4] = cfg.priority_weight;
            seq[5] = 8'd0;
        end

        for (int i = 0; i < hfs_pkg::PLAN_DEPTH; i++)
        begin
            plan[i] = '0;
        end
        plan[0]    = status_entry;
        plan_count = hfs_pkg::CNT_W'(1);
        state_next = state;

        case (opcode)
            hfs_pkg::OP_BEGIN:
            begin
                if (state.block_open || state.block_done)
                begin
                    plan[0] = status_entry;
                end
                else if (cfg_bad)
                begin
                    plan[0].status = hfs_pkg::STATUS_BAD_CFG;
                end
                else
                begin
                    state_next.block_open     = 1'b1;
                    state_next.in_first_frame = 1'b1;
                    state_next.bytes_in_frame = hfs_pkg::LEN_W'(prefix_n);
                    if (prefix_n == '0)
                    begin
                        plan[0].status = hfs_pkg::STATUS_OK;
                    end
                    else
                    begin
                        plan_count = prefix_n;
                        for (int i = 0; i < hfs_pkg::PLAN_DEPTH; i++)
                        begin
                            if (hfs_pkg::CNT_W'(i) < prefix_n)
                            begin
                                plan[i]           = '0;
                                plan[i].item_kind = hfs_pkg::KIND_PAYLOAD;
                                plan[i].out_byte  = seq[i];
                            end
                        end
                    end
                end
            end
            hfs_pkg::OP_BYTE:
            begin
                if (state.block_open && cfg.max_frame_payload != '0)
                begin
                    if (room_zero)
                    begin
                        state_next.in_first_frame = 1'b0;
                        state_next.bytes_in_frame = hfs_pkg::LEN_W'(1);
                        if (pend_pad != 8'd0)
                        begin
                            plan[0]    = pad_entry;
                            plan[1]    = hdr_entry;
                            plan[2]    = byte_entry;
                            plan_count = hfs_pkg::CNT_W'(3);
                        end
                        else
                        begin
                            plan[0]    = hdr_entry;
                            plan[1]    = byte_entry;
                            plan_count = hfs_pkg::CNT_W'(2);
                        end
                    end
                    else
                    begin
                        plan[0] = byte_entry;
                        state_next.bytes_in_frame = state.bytes_in_frame + hfs_pkg::LEN_W'(1);
                    end
                end
            end
            hfs_pkg::OP_FINISH:
            begin
                if (state.block_open)
                begin
                    state_next.block_open     = 1'b0;
                    state_next.block_done     = 1'b1;
                    state_next.in_first_frame = 1'b0;
                    state_next.bytes_in_frame = '0;
                    if (pend_pad != 8'd0)
                    begin
                        plan[0]             = pad_entry;
                        plan[1]             = hdr_entry;
                        plan[1].frame_flags = first_flags | hfs_pkg::FLAG_END_HEADERS;
                        plan_count          = hfs_pkg::CNT_W'(2);
                    end
                    else
                    begin
                        plan[0]             = hdr_entry;
                        plan[0].frame_flags = first_flags | hfs_pkg::FLAG_END_HEADERS;
                    end
                end
            end
            default:
            begin
                plan[0] = status_entry;
            end
        endcase

        for (int i = 0; i < hfs_pkg::PLAN_DEPTH; i++)
        begin
            plan[i].last_of_run = (hfs_pkg::CNT_W'(i) == plan_count - hfs_pkg::CNT_W'(1));
        end
    end

endmodule
